// ----- hw/rtl/pcrs_pkg.sv -----
// Shared types, constants and helpers for the PID controller with reference smoothing.
package pcrs_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int STEPS_PER_SECOND = 100;
    localparam int ALPHA_SHIFT      = 15;
    localparam int MUL_A_W          = 34;
    localparam int MUL_B_W          = 32;
    localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W          = 34 + FRAC_BITS;
    localparam int DIV_D_W          = 32;

    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;
    localparam logic [15:0] ALPHA_ONE = 16'd32768;

    localparam int MODE_SCURVE = 0;
    localparam int MODE_TRAP   = 1;
    localparam int MODE_VRATE  = 2;
    localparam int MODE_ICLAMP = 3;
    localparam int MODE_DMEAS  = 4;
    localparam int MODE_DFILT  = 5;
    localparam int MODE_OFILT  = 6;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_LIMITS = 3'd4,
        CFG_BANDS  = 3'd5,
        CFG_DEADA  = 3'd6,
        CFG_SMOOTH = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SC_DIFF,
        ST_SC_TGT,
        ST_SC_ACC,
        ST_SC_SPD,
        ST_SC_REF,
        ST_ERR,
        ST_INT_D,
        ST_INT_R,
        ST_INT_M,
        ST_CLAMP,
        ST_DER,
        ST_LPD1,
        ST_LPD2,
        ST_PROP,
        ST_OUT,
        ST_LPO1,
        ST_LPO2,
        ST_FIN
    } t_state;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > MAX32) r = MAX32;
        if (v < MIN32) r = MIN32;
        return r;
    endfunction

    function automatic logic signed [63:0] clampsym(input logic signed [63:0] v,
                                                    input logic signed [63:0] lim);
        logic signed [63:0] r;
        r = v;
        if (v > lim) r = lim;
        if (v < -lim) r = -lim;
        return r;
    endfunction

endpackage

// ----- hw/rtl/pcrs_req_if.sv -----
// Request channel: one measurement and one reference.
interface pcrs_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_value;
    logic signed [31:0] reference_value;
    modport source(output valid, measured_value, reference_value, input ready);
    modport sink(input valid, measured_value, reference_value, output ready);
endinterface

// ----- hw/rtl/pcrs_res_if.sv -----
// Result channel: one drive value.
interface pcrs_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_value;
    modport source(output valid, drive_value, input ready);
    modport sink(input valid, drive_value, output ready);
endinterface

// ----- hw/rtl/pcrs_mul.sv -----
// Bit-serial shift-add multiplier, signed by unsigned, one multiplier bit per cycle.
module pcrs_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pcrs_pkg::MUL_A_W-1:0]   i_a,
    input  logic        [pcrs_pkg::MUL_B_W-1:0]   i_b,
    output logic                                  o_done,
    output logic signed [pcrs_pkg::MUL_P_W-1:0]   o_p
);
    localparam int CW = $clog2(pcrs_pkg::MUL_B_W);

    logic                                r_busy, r_done;
    logic [CW-1:0]                       r_cnt;
    logic signed [pcrs_pkg::MUL_P_W-1:0] r_acc, r_a;
    logic [pcrs_pkg::MUL_B_W-1:0]        r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(pcrs_pkg::MUL_B_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(pcrs_pkg::MUL_B_W - 1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= pcrs_pkg::MUL_P_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// ----- hw/rtl/pcrs_div.sv -----
// Restoring divider, unsigned, one quotient bit per cycle.
module pcrs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pcrs_pkg::DIV_N_W-1:0]      i_num,
    input  logic [pcrs_pkg::DIV_D_W-1:0]      i_den,
    output logic                              o_done,
    output logic [pcrs_pkg::DIV_N_W-1:0]      o_q
);
    localparam int CW = $clog2(pcrs_pkg::DIV_N_W);

    logic                              r_busy, r_done;
    logic [CW-1:0]                     r_cnt;
    logic [pcrs_pkg::DIV_N_W-1:0]      r_q;
    logic [pcrs_pkg::DIV_D_W:0]        r_rem;
    logic [pcrs_pkg::DIV_D_W-1:0]      r_den;
    logic [pcrs_pkg::DIV_D_W:0]        rem_sh;

    assign rem_sh = {r_rem[pcrs_pkg::DIV_D_W-1:0], r_q[pcrs_pkg::DIV_N_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(pcrs_pkg::DIV_N_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(pcrs_pkg::DIV_N_W - 1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sh - {1'b0, r_den};
                r_q   <= {r_q[pcrs_pkg::DIV_N_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[pcrs_pkg::DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ----- hw/rtl/pid_controller_with_ref_smoothing.sv -----
// PID controller with S-curve reference smoothing: sequencer, state and config registers.
// One request (measurement, reference) gives one clamped drive value, all Q16.16.
// Requests are taken one at a time; the work on each is set by the shared
// bit-serial multiplier (up to ten products) and the restoring divider (up to
// three quotients with smoothing and tapered integration). A finished result
// waits in the output register while the next request is taken. Registers are
// to be written only while the block is idle; the block itself does not enforce this.
module pid_controller_with_ref_smoothing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcrs_req_if.sink    i_req,
    pcrs_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    localparam int F = pcrs_pkg::FRAC_BITS;

    pcrs_pkg::t_state r_state, n_state;

    logic [6:0]  r_mode;
    logic [30:0] r_kp, r_ki, r_kd;
    logic [63:0] r_lim, r_bands, r_db, r_smooth;

    logic signed [31:0] r_meas, r_ref, r_sref, r_spd, r_acc, r_isum;
    logic signed [31:0] r_perr, r_pmeas, r_pder, r_pout;
    logic signed [31:0] r_diff, r_err, r_delta, r_dout;
    logic signed [31:0] n_meas, n_ref, n_sref, n_spd, n_acc, n_isum;
    logic signed [31:0] n_perr, n_pmeas, n_pder, n_pout;
    logic signed [31:0] n_diff, n_err, n_delta, n_dout;
    logic [31:0]        r_abs, n_abs;
    logic signed [63:0] r_t, n_t;
    logic               r_started, n_started, r_dneg, n_dneg;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_drive, n_drive;

    logic                                  mul_start, mul_done;
    logic signed [pcrs_pkg::MUL_A_W-1:0]   mul_a;
    logic [pcrs_pkg::MUL_B_W-1:0]          mul_b;
    logic signed [pcrs_pkg::MUL_P_W-1:0]   mul_p;
    logic                                  div_start, div_done;
    logic [pcrs_pkg::DIV_N_W-1:0]          div_num, div_q;
    logic [pcrs_pkg::DIV_D_W-1:0]          div_den;

    pcrs_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    pcrs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_q(div_q)
    );

    logic signed [63:0] out_lim, int_lim, band_a, band_b, dead, max_acc, max_jerk;
    logic signed [63:0] kp64, pq, pshift, qs;
    logic [15:0]        alpha_d, alpha_o;

    assign out_lim  = $signed({32'd0, r_lim[63:32]});
    assign int_lim  = $signed({32'd0, r_lim[31:0]});
    assign band_a   = $signed({32'd0, r_bands[63:32]});
    assign band_b   = $signed({32'd0, r_bands[31:0]});
    assign dead     = $signed({32'd0, r_db[63:32]});
    assign max_acc  = $signed({32'd0, r_smooth[63:32]});
    assign max_jerk = $signed({32'd0, r_smooth[31:0]});
    assign kp64     = $signed({33'd0, r_kp});
    assign alpha_d  = (r_db[31:16] > pcrs_pkg::ALPHA_ONE) ? pcrs_pkg::ALPHA_ONE : r_db[31:16];
    assign alpha_o  = (r_db[15:0] > pcrs_pkg::ALPHA_ONE) ? pcrs_pkg::ALPHA_ONE : r_db[15:0];
    assign pq       = 64'(mul_p);
    assign pshift   = 64'(mul_p >>> F);
    assign qs       = r_dneg ? -$signed({14'd0, div_q}) : $signed({14'd0, div_q});

    assign i_req.ready       = (r_state == pcrs_pkg::ST_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.drive_value = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_lim    <= '0;
            r_bands  <= '0;
            r_db     <= '0;
            r_smooth <= '0;
        end else if (i_cfg_we) begin
            unique case (pcrs_pkg::t_cfg_idx'(i_cfg_idx))
                pcrs_pkg::CFG_MODE:   r_mode   <= i_cfg_data[6:0];
                pcrs_pkg::CFG_KP:     r_kp     <= i_cfg_data[30:0];
                pcrs_pkg::CFG_KI:     r_ki     <= i_cfg_data[30:0];
                pcrs_pkg::CFG_KD:     r_kd     <= i_cfg_data[30:0];
                pcrs_pkg::CFG_LIMITS: r_lim    <= i_cfg_data;
                pcrs_pkg::CFG_BANDS:  r_bands  <= i_cfg_data;
                pcrs_pkg::CFG_DEADA:  r_db     <= i_cfg_data;
                pcrs_pkg::CFG_SMOOTH: r_smooth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcrs_pkg::ST_IDLE;
            r_sref    <= '0;
            r_spd     <= '0;
            r_acc     <= '0;
            r_started <= 1'b0;
            r_isum    <= '0;
            r_perr    <= '0;
            r_pmeas   <= '0;
            r_pder    <= '0;
            r_pout    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sref    <= n_sref;
            r_spd     <= n_spd;
            r_acc     <= n_acc;
            r_started <= n_started;
            r_isum    <= n_isum;
            r_perr    <= n_perr;
            r_pmeas   <= n_pmeas;
            r_pder    <= n_pder;
            r_pout    <= n_pout;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas  <= n_meas;
        r_ref   <= n_ref;
        r_diff  <= n_diff;
        r_err   <= n_err;
        r_abs   <= n_abs;
        r_delta <= n_delta;
        r_dout  <= n_dout;
        r_t     <= n_t;
        r_dneg  <= n_dneg;
        r_drive <= n_drive;
    end

    always_comb begin
        logic signed [63:0] v, w, x;
        logic [31:0]        ua;
        n_state   = r_state;
        n_meas    = r_meas;
        n_ref     = r_ref;
        n_sref    = r_sref;
        n_spd     = r_spd;
        n_acc     = r_acc;
        n_started = r_started;
        n_isum    = r_isum;
        n_perr    = r_perr;
        n_pmeas   = r_pmeas;
        n_pder    = r_pder;
        n_pout    = r_pout;
        n_diff    = r_diff;
        n_err     = r_err;
        n_abs     = r_abs;
        n_delta   = r_delta;
        n_dout    = r_dout;
        n_t       = r_t;
        n_dneg    = r_dneg;
        n_drive   = r_drive;
        n_ovalid  = r_ovalid && !o_res.ready;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        v = '0;
        w = '0;
        x = '0;
        ua = '0;
        unique case (r_state)
            pcrs_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_meas = i_req.measured_value;
                    n_ref  = i_req.reference_value;
                    if (r_mode[pcrs_pkg::MODE_SCURVE]) begin
                        if (!r_started) begin
                            n_sref    = i_req.reference_value;
                            n_spd     = '0;
                            n_acc     = '0;
                            n_started = 1'b1;
                        end
                        n_state = pcrs_pkg::ST_SC_DIFF;
                    end else begin
                        n_sref  = i_req.reference_value;
                        n_state = pcrs_pkg::ST_ERR;
                    end
                end
            end
            pcrs_pkg::ST_SC_DIFF: begin
                v = pcrs_pkg::sat32(64'(r_ref) - 64'(r_sref));
                n_diff    = 32'(v);
                mul_start = 1'b1;
                mul_a     = 34'(v);
                mul_b     = {1'b0, r_kp};
                n_state   = pcrs_pkg::ST_SC_TGT;
            end
            pcrs_pkg::ST_SC_TGT: begin
                if (mul_done) begin
                    v = pcrs_pkg::clampsym(pshift, out_lim) - 64'(r_spd);
                    mul_start = 1'b1;
                    mul_a     = 34'(v);
                    mul_b     = 32'(pcrs_pkg::STEPS_PER_SECOND);
                    n_state   = pcrs_pkg::ST_SC_ACC;
                end
            end
            pcrs_pkg::ST_SC_ACC: begin
                if (mul_done) begin
                    v = pcrs_pkg::clampsym(pq, max_acc);
                    w = pcrs_pkg::clampsym(v - 64'(r_acc), max_jerk);
                    x = pcrs_pkg::sat32(64'(r_acc) + w);
                    n_acc     = 32'(x);
                    n_dneg    = x[63];
                    ua        = x[63] ? 32'(-x) : 32'(x);
                    div_start = 1'b1;
                    div_num   = pcrs_pkg::DIV_N_W'(ua);
                    div_den   = 32'(pcrs_pkg::STEPS_PER_SECOND);
                    n_state   = pcrs_pkg::ST_SC_SPD;
                end
            end
            pcrs_pkg::ST_SC_SPD: begin
                if (div_done) begin
                    x = pcrs_pkg::sat32(64'(r_spd) + qs);
                    n_spd     = 32'(x);
                    n_dneg    = x[63];
                    ua        = x[63] ? 32'(-x) : 32'(x);
                    div_start = 1'b1;
                    div_num   = pcrs_pkg::DIV_N_W'(ua);
                    div_den   = 32'(pcrs_pkg::STEPS_PER_SECOND);
                    n_state   = pcrs_pkg::ST_SC_REF;
                end
            end
            pcrs_pkg::ST_SC_REF: begin
                if (div_done) begin
                    x = pcrs_pkg::sat32(64'(r_sref) + qs);
                    n_sref = 32'(x);
                    if ((r_diff > 0 && x > 64'(r_ref)) || (r_diff < 0 && x < 64'(r_ref))) begin
                        n_sref = r_ref;
                        n_spd  = '0;
                        n_acc  = '0;
                    end
                    n_state = pcrs_pkg::ST_ERR;
                end
            end
            pcrs_pkg::ST_ERR: begin
                v = pcrs_pkg::sat32(64'(r_sref) - 64'(r_meas));
                w = v[63] ? -v : v;
                if (w <= dead) begin
                    v = '0;
                    w = '0;
                end
                n_err     = 32'(v);
                n_abs     = 32'(w);
                mul_start = 1'b1;
                mul_a     = r_mode[pcrs_pkg::MODE_TRAP] ? 34'(v + 64'(r_perr)) : 34'(v);
                mul_b     = {1'b0, r_ki};
                n_state   = pcrs_pkg::ST_INT_D;
            end
            pcrs_pkg::ST_INT_D: begin
                if (mul_done) begin
                    v = r_mode[pcrs_pkg::MODE_TRAP] ? 64'(mul_p >>> (F + 1)) : pshift;
                    v = pcrs_pkg::sat32(v);
                    n_delta = 32'(v);
                    n_state = pcrs_pkg::ST_CLAMP;
                    w = $signed({32'd0, r_abs});
                    if (!r_mode[pcrs_pkg::MODE_VRATE] || w <= band_b) begin
                        n_isum = 32'(pcrs_pkg::sat32(64'(r_isum) + v));
                    end else if (w <= band_a + band_b && band_a > 0) begin
                        x = band_a + band_b - w;
                        div_start = 1'b1;
                        div_num   = pcrs_pkg::DIV_N_W'(x) << F;
                        div_den   = r_bands[63:32];
                        n_state   = pcrs_pkg::ST_INT_R;
                    end
                end
            end
            pcrs_pkg::ST_INT_R: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = 34'(r_delta);
                    mul_b     = div_q[31:0];
                    n_state   = pcrs_pkg::ST_INT_M;
                end
            end
            pcrs_pkg::ST_INT_M: begin
                if (mul_done) begin
                    n_isum  = 32'(pcrs_pkg::sat32(64'(r_isum) + pshift));
                    n_state = pcrs_pkg::ST_CLAMP;
                end
            end
            pcrs_pkg::ST_CLAMP: begin
                if (r_mode[pcrs_pkg::MODE_ICLAMP])
                    n_isum = 32'(pcrs_pkg::clampsym(64'(r_isum), int_lim));
                mul_start = 1'b1;
                mul_a     = r_mode[pcrs_pkg::MODE_DMEAS] ? 34'(64'(r_pmeas) - 64'(r_meas))
                                                         : 34'(64'(r_err) - 64'(r_perr));
                mul_b     = {1'b0, r_kd};
                n_state   = pcrs_pkg::ST_DER;
            end
            pcrs_pkg::ST_DER: begin
                if (mul_done) begin
                    v = pcrs_pkg::sat32(pshift);
                    n_dout = 32'(v);
                    if (r_mode[pcrs_pkg::MODE_DFILT]) begin
                        mul_start = 1'b1;
                        mul_a     = 34'(v);
                        mul_b     = {16'd0, alpha_d};
                        n_state   = pcrs_pkg::ST_LPD1;
                    end else begin
                        n_state   = pcrs_pkg::ST_PROP;
                    end
                end
            end
            pcrs_pkg::ST_LPD1: begin
                if (mul_done) begin
                    n_t       = pq;
                    mul_start = 1'b1;
                    mul_a     = 34'(r_pder);
                    mul_b     = {16'd0, 16'(pcrs_pkg::ALPHA_ONE - alpha_d)};
                    n_state   = pcrs_pkg::ST_LPD2;
                end
            end
            pcrs_pkg::ST_LPD2: begin
                if (mul_done) begin
                    n_dout  = 32'(pcrs_pkg::sat32((r_t + pq) >>> pcrs_pkg::ALPHA_SHIFT));
                    n_state = pcrs_pkg::ST_PROP;
                end
            end
            pcrs_pkg::ST_PROP: begin
                mul_start = 1'b1;
                mul_a     = 34'(r_err);
                mul_b     = 32'(kp64);
                n_state   = pcrs_pkg::ST_OUT;
            end
            pcrs_pkg::ST_OUT: begin
                if (mul_done) begin
                    v = pshift + 64'(r_isum) + 64'(r_dout);
                    n_t = v;
                    if (r_mode[pcrs_pkg::MODE_OFILT]) begin
                        mul_start = 1'b1;
                        mul_a     = 34'(pcrs_pkg::sat32(v));
                        mul_b     = {16'd0, alpha_o};
                        n_state   = pcrs_pkg::ST_LPO1;
                    end else begin
                        n_state   = pcrs_pkg::ST_FIN;
                    end
                end
            end
            pcrs_pkg::ST_LPO1: begin
                if (mul_done) begin
                    n_t       = pq;
                    mul_start = 1'b1;
                    mul_a     = 34'(r_pout);
                    mul_b     = {16'd0, 16'(pcrs_pkg::ALPHA_ONE - alpha_o)};
                    n_state   = pcrs_pkg::ST_LPO2;
                end
            end
            pcrs_pkg::ST_LPO2: begin
                if (mul_done) begin
                    n_t     = (r_t + pq) >>> pcrs_pkg::ALPHA_SHIFT;
                    n_state = pcrs_pkg::ST_FIN;
                end
            end
            pcrs_pkg::ST_FIN: begin
                if (!r_ovalid || o_res.ready) begin
                    v = pcrs_pkg::sat32(pcrs_pkg::clampsym(r_t, out_lim));
                    n_pmeas  = r_meas;
                    n_perr   = r_err;
                    n_pout   = 32'(v);
                    n_pder   = r_dout;
                    n_drive  = 32'(v);
                    n_ovalid = 1'b1;
                    n_state  = pcrs_pkg::ST_IDLE;
                end
            end
            default: n_state = pcrs_pkg::ST_IDLE;
        endcase
    end
endmodule

// ----- hw/rtl/pcrs_checker.sv -----
// Port-level checks for the PID controller, bound to the top level.
module pcrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_drive
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_drive))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !$past(i_res_valid) && $past(i_rst_n) |-> !$past(i_req_ready))
        else $error("result appeared without work");
endmodule

bind pid_controller_with_ref_smoothing pcrs_checker u_pcrs_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_drive(o_res.drive_value)
);
